// File: hdl/iqd_pkg.sv
// Types and constants shared by the IQ sample packet deframer modules.
`default_nettype none

package iqd_pkg;

  localparam logic [7:0]  MAGIC_FIRST  = 8'h44;
  localparam logic [7:0]  MAGIC_SECOND = 8'h41;
  localparam logic [23:0] OFFSET_BIT   = 24'h800000;

  // Position within the datagram header; the payload position covers the rest.
  typedef enum logic [2:0] {
    HP_MAGIC0  = 3'd0,
    HP_MAGIC1  = 3'd1,
    HP_SEQ_HI  = 3'd2,
    HP_SEQ_LO  = 3'd3,
    HP_COUNT   = 3'd4,
    HP_PAYLOAD = 3'd5
  } hpos_t;

  // Byte index within one six-byte sample.
  typedef enum logic [2:0] {
    SB_I0 = 3'd0,
    SB_I1 = 3'd1,
    SB_I2 = 3'd2,
    SB_Q0 = 3'd3,
    SB_Q1 = 3'd4,
    SB_Q2 = 3'd5
  } sbyte_t;

  typedef enum logic [1:0] {
    ST_SAMPLE    = 2'd0,
    ST_BAD_MAGIC = 2'd1,
    ST_SHORT     = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_datagram;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] i_sample;
    logic signed [23:0] q_sample;
    logic [15:0]        seq_number;
    logic [7:0]         sample_index;
    logic               last_sample;
    status_t            status;
  } out_item_t;

endpackage

`default_nettype wire

// File: hdl/iqd_parser.sv
// Datagram parser: header state, sample assembly and result formation per byte.
`default_nettype none

module iqd_parser
  import iqd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      accept,
  input  wire in_item_t  item,
  output logic           res_valid,
  output out_item_t      res
);

  hpos_t       hpos, hpos_next;
  logic        discarding, discarding_next;
  logic [15:0] seq, seq_next;
  logic [7:0]  count, count_next;
  logic [7:0]  done, done_next;
  sbyte_t      sbyte, sbyte_next;
  logic [23:0] i_acc, i_acc_next;
  logic [15:0] q_high, q_high_next;

  always_comb begin
    logic        have_sample;
    logic [23:0] si;
    logic [23:0] sq;
    logic [7:0]  sidx;
    logic        slast;
    logic        bad_magic;
    logic        shortp;
    logic [7:0]  done_inc;

    hpos_next       = hpos;
    discarding_next = discarding;
    seq_next        = seq;
    count_next      = count;
    done_next       = done;
    sbyte_next      = sbyte;
    i_acc_next      = i_acc;
    q_high_next     = q_high;
    have_sample     = 1'b0;
    si              = '0;
    sq              = '0;
    sidx            = '0;
    slast           = 1'b0;
    bad_magic       = 1'b0;
    shortp          = 1'b0;
    done_inc        = done + 8'd1;
    res_valid       = 1'b0;
    res             = '0;

    if (discarding) begin
      if (item.end_of_datagram) begin
        hpos_next       = HP_MAGIC0;
        discarding_next = 1'b0;
        sbyte_next      = SB_I0;
      end
    end else begin
      unique case (hpos)
        HP_MAGIC0: begin
          if (item.data_byte != MAGIC_FIRST) bad_magic = 1'b1;
          else hpos_next = HP_MAGIC1;
        end
        HP_MAGIC1: begin
          if (item.data_byte != MAGIC_SECOND) bad_magic = 1'b1;
          else hpos_next = HP_SEQ_HI;
        end
        HP_SEQ_HI: begin
          seq_next  = {item.data_byte, seq[7:0]};
          hpos_next = HP_SEQ_LO;
        end
        HP_SEQ_LO: begin
          seq_next  = {seq[15:8], item.data_byte};
          hpos_next = HP_COUNT;
        end
        HP_COUNT: begin
          count_next = item.data_byte;
          done_next  = '0;
          sbyte_next = SB_I0;
          hpos_next  = HP_PAYLOAD;
        end
        default: begin
          // Bytes past the announced count fall through untouched.
          if (done < count) begin
            unique case (sbyte)
              SB_I0, SB_I1, SB_I2: begin
                i_acc_next = {i_acc[15:0], item.data_byte};
                sbyte_next = sbyte_t'(sbyte + 3'd1);
              end
              SB_Q0, SB_Q1: begin
                q_high_next = {q_high[7:0], item.data_byte};
                sbyte_next  = sbyte_t'(sbyte + 3'd1);
              end
              default: begin
                si          = i_acc ^ OFFSET_BIT;
                sq          = {q_high, item.data_byte} ^ OFFSET_BIT;
                sidx        = done;
                slast       = (done_inc == count);
                done_next   = done_inc;
                sbyte_next  = SB_I0;
                have_sample = 1'b1;
              end
            endcase
          end
        end
      endcase

      if (bad_magic) begin
        res_valid  = 1'b1;
        res.status = ST_BAD_MAGIC;
        if (item.end_of_datagram) begin
          hpos_next  = HP_MAGIC0;
          sbyte_next = SB_I0;
        end else begin
          discarding_next = 1'b1;
        end
      end else begin
        if (item.end_of_datagram) begin
          shortp     = (hpos_next != HP_PAYLOAD) || (done_next < count_next);
          hpos_next  = HP_MAGIC0;
          sbyte_next = SB_I0;
        end
        if (shortp) begin
          res_valid          = 1'b1;
          res.status         = ST_SHORT;
          res.seq_number     = seq_next;
          res.i_sample       = si;
          res.q_sample       = sq;
          res.sample_index   = have_sample ? sidx : done_next;
          res.last_sample    = 1'b0;
        end else if (have_sample) begin
          res_valid          = 1'b1;
          res.status         = ST_SAMPLE;
          res.seq_number     = seq_next;
          res.i_sample       = si;
          res.q_sample       = sq;
          res.sample_index   = sidx;
          res.last_sample    = slast;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hpos       <= HP_MAGIC0;
      discarding <= 1'b0;
      seq        <= '0;
      count      <= '0;
      done       <= '0;
      sbyte      <= SB_I0;
      i_acc      <= '0;
      q_high     <= '0;
    end else if (accept) begin
      hpos       <= hpos_next;
      discarding <= discarding_next;
      seq        <= seq_next;
      count      <= count_next;
      done       <= done_next;
      sbyte      <= sbyte_next;
      i_acc      <= i_acc_next;
      q_high     <= q_high_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/iq_sample_packet_deframer.sv
// Top level of the IQ sample packet deframer: parser and registered result stage.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------------
//   in      | in_valid / in_stall  | in_item  (data_byte, end_of_datagram)
//   out     | out_valid / out_stall| out_item (I, Q, sequence, index, status)
//
// One byte is taken per clock; its result, if any, is in the output register
// on the next cycle. The per-byte parse and the output register set that rate.
// Reset clears the header state, so the first byte after it is taken as 'D'.
// The input stalls only while a result waits in the output register and the
// output is stalled; bytes keep flowing whenever that register can be emptied.
`default_nettype none

module iq_sample_packet_deframer
  import iqd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item
);

  logic      accept;
  logic      load_en;
  logic      res_valid;
  out_item_t res;

  assign load_en  = !out_valid || !out_stall;
  assign in_stall = !load_en;
  assign accept   = in_valid && load_en;

  iqd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (in_item),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_en) begin
      out_valid <= accept && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en && accept && res_valid) begin
      out_item <= res;
    end
  end

`ifndef SYNTHESIS
  // A byte that yields a result must appear at the output on the next cycle.
  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    (accept && res_valid) |=> out_valid)
    else $error("result of an accepted byte was lost");

  a_bad_magic_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.status == ST_BAD_MAGIC) |->
      (out_item.i_sample == '0 && out_item.q_sample == '0 &&
       out_item.seq_number == '0 && out_item.sample_index == '0 &&
       !out_item.last_sample))
    else $error("bad magic result carries nonzero fields");

  a_last_is_sample: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.last_sample) |-> (out_item.status == ST_SAMPLE))
    else $error("last sample flag set on an error result");
`endif

endmodule

`default_nettype wire
